// File: rtl/logm_pkg.sv
// Shared types, codes and constants of the logistic value and gradient pipeline.
package logm_pkg;

   localparam int Q_BITS = 32;
   localparam int EXP_TERMS = 14;
   localparam int POW_STAGES = 31;
   localparam int CSR_INDEX_W = 2;

   // 1.0 and exp(-1) in unsigned Q32, the latter as the truncated series gives it
   localparam logic [Q_BITS:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [Q_BITS-1:0] EXP_NEG_ONE = 32'd1580030169;

   localparam logic [1:0] DERIV_A = 2'd0;
   localparam logic [1:0] DERIV_B = 2'd1;
   localparam logic [1:0] DERIV_C = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_B = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_C = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       big;
      logic       nt;
      logic       nd;
      logic [1:0] sel;
   } logm_ctl_type;

   // floor(2^36 / k): reciprocal used for the series division by k
   function automatic logic [36:0] taylor_recip(input int k);
      logic [36:0] r;
      case (k)
         2:       r = 37'd34359738368;
         3:       r = 37'd22906492245;
         4:       r = 37'd17179869184;
         5:       r = 37'd13743895347;
         6:       r = 37'd11453246122;
         7:       r = 37'd9817068105;
         8:       r = 37'd8589934592;
         9:       r = 37'd7635497415;
         10:      r = 37'd6871947673;
         11:      r = 37'd6247225157;
         12:      r = 37'd5726623061;
         13:      r = 37'd5286113595;
         14:      r = 37'd4908534052;
         default: r = 37'd68719476736;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/logm_if.sv
// Request and response channel interfaces of the logistic pipeline.
interface logm_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_value;
   logic [1:0]                   derivative_index;

   modport source (output valid, output x_value, output derivative_index, input ready);
   modport sink (input valid, input x_value, input derivative_index, output ready);
endinterface

interface logm_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] model_value;
   logic signed [DATA_WIDTH-1:0] partial_value;
   logic                         saturated;

   modport source (output valid, output model_value, output partial_value, output saturated,
                   input ready);
   modport sink (input valid, input model_value, input partial_value, input saturated,
                 output ready);
endinterface

// File: rtl/logm_exp.sv
// Pipelined exp(-|t|): Taylor series on the fraction, then one exp(-1) step per integer unit.
module logm_exp
   import logm_pkg::*;
#(
   parameter int SIDE_W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logm_ctl_type        ctl_in,
   input  logic [4:0]          n_in,
   input  logic [Q_BITS-1:0]   f_in,
   input  logic [SIDE_W-1:0]   side_in,
   output logm_ctl_type        ctl_out,
   output logic [Q_BITS:0]     e_out,
   output logic [SIDE_W-1:0]   side_out
);

   typedef struct packed {
      logic [4:0]        n;
      logic [Q_BITS-1:0] f;
      logic [SIDE_W-1:0] side;
   } exp_pay_type;

   logm_ctl_type      ctl_t [0:EXP_TERMS];
   exp_pay_type       pay_t [0:EXP_TERMS];
   logic [Q_BITS:0]   term_t [0:EXP_TERMS];
   logic [Q_BITS+2:0] sum_t [0:EXP_TERMS];

   assign ctl_t[0] = ctl_in;
   assign pay_t[0] = '{n: n_in, f: f_in, side: side_in};
   assign term_t[0] = ONE_Q32;
   assign sum_t[0] = 35'(ONE_Q32);

   // three stages per term: multiply by f, multiply by 1/k, correct and accumulate
   for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
      localparam logic [36:0] RECIP = taylor_recip(k);

      logm_ctl_type      ctl_a_ff, ctl_b_ff, ctl_c_ff;
      exp_pay_type       pay_a_ff, pay_b_ff, pay_c_ff;
      logic [64:0]       prod_a;
      logic [Q_BITS:0]   tr_a_in, tr_a_ff, tr_b_ff;
      logic [69:0]       prod_b;
      logic [Q_BITS:0]   q0_b_in, q0_b_ff;
      logic [Q_BITS+1:0] rem_c;
      logic [Q_BITS:0]   term_c_in, term_c_ff;
      logic [Q_BITS+2:0] sum_a_ff, sum_b_ff, sum_c_in, sum_c_ff;

      always_comb begin
         prod_a = 65'(term_t[k-1]) * 65'(pay_t[k-1].f);
         tr_a_in = prod_a[64:32];
         prod_b = 70'(tr_a_ff) * 70'(RECIP);
         q0_b_in = prod_b[68:36];
         rem_c = 34'(tr_b_ff) - 34'(q0_b_ff) * 34'(k);
         term_c_in = (rem_c >= 34'(k)) ? q0_b_ff + 33'd1 : q0_b_ff;
         if (k % 2 == 1) begin
            sum_c_in = sum_b_ff - 35'(term_c_in);
         end else begin
            sum_c_in = sum_b_ff + 35'(term_c_in);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_a_ff <= '0;
            ctl_b_ff <= '0;
            ctl_c_ff <= '0;
         end else if (advance) begin
            ctl_a_ff <= ctl_t[k-1];
            ctl_b_ff <= ctl_a_ff;
            ctl_c_ff <= ctl_b_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pay_a_ff <= pay_t[k-1];
            tr_a_ff <= tr_a_in;
            sum_a_ff <= sum_t[k-1];
            pay_b_ff <= pay_a_ff;
            tr_b_ff <= tr_a_ff;
            q0_b_ff <= q0_b_in;
            sum_b_ff <= sum_a_ff;
            pay_c_ff <= pay_b_ff;
            term_c_ff <= term_c_in;
            sum_c_ff <= sum_c_in;
         end
      end

      assign ctl_t[k] = ctl_c_ff;
      assign pay_t[k] = pay_c_ff;
      assign term_t[k] = term_c_ff;
      assign sum_t[k] = sum_c_ff;
   end

   // clamp the series to [0, 1.0]
   logm_ctl_type      pw_ctl [0:POW_STAGES];
   logic [4:0]        pw_n [0:POW_STAGES];
   logic [SIDE_W-1:0] pw_side [0:POW_STAGES];
   logic [Q_BITS:0]   pw_e [0:POW_STAGES];

   logm_ctl_type      cl_ctl_ff;
   logic [4:0]        cl_n_ff;
   logic [SIDE_W-1:0] cl_side_ff;
   logic [Q_BITS:0]   cl_e_in, cl_e_ff;

   always_comb begin
      if (sum_t[EXP_TERMS][Q_BITS+2]) begin
         cl_e_in = '0;
      end else if (sum_t[EXP_TERMS][Q_BITS+1:0] > 34'(ONE_Q32)) begin
         cl_e_in = ONE_Q32;
      end else begin
         cl_e_in = sum_t[EXP_TERMS][Q_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_ctl_ff <= '0;
      end else if (advance) begin
         cl_ctl_ff <= ctl_t[EXP_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cl_n_ff <= pay_t[EXP_TERMS].n;
         cl_side_ff <= pay_t[EXP_TERMS].side;
         cl_e_ff <= cl_e_in;
      end
   end

   assign pw_ctl[0] = cl_ctl_ff;
   assign pw_n[0] = cl_n_ff;
   assign pw_side[0] = cl_side_ff;
   assign pw_e[0] = cl_e_ff;

   // stage i multiplies by exp(-1) when the integer part exceeds i
   for (genvar i = 0; i < POW_STAGES; i++) begin : g_pow
      logm_ctl_type      ctl_ff;
      logic [4:0]        n_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [64:0]       prod;
      logic [Q_BITS:0]   e_in, e_ff;

      always_comb begin
         prod = 65'(pw_e[i]) * 65'(EXP_NEG_ONE) + (65'(1) << 31);
         e_in = (pw_n[i] > 5'(i)) ? prod[64:32] : pw_e[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (advance) begin
            ctl_ff <= pw_ctl[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            n_ff <= pw_n[i];
            side_ff <= pw_side[i];
            e_ff <= e_in;
         end
      end

      assign pw_ctl[i+1] = ctl_ff;
      assign pw_n[i+1] = n_ff;
      assign pw_side[i+1] = side_ff;
      assign pw_e[i+1] = e_ff;
   end

   assign ctl_out = pw_ctl[POW_STAGES];
   assign side_out = pw_side[POW_STAGES];
   assign e_out = pw_ctl[POW_STAGES].big ? '0 : pw_e[POW_STAGES];

endmodule

// File: rtl/logm_recip.sv
// Pipelined restoring divider: p = 1/(1+e) in Q31, rounded, one quotient bit per stage.
module logm_recip
   import logm_pkg::*;
#(
   parameter int SIDE_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logm_ctl_type      ctl_in,
   input  logic [Q_BITS:0]   e_in,
   input  logic [SIDE_W-1:0] side_in,
   output logm_ctl_type      ctl_out,
   output logic [Q_BITS-1:0] p_out,
   output logic [SIDE_W-1:0] side_out
);

   localparam int STEPS = Q_BITS;

   logm_ctl_type      ctl_t [0:STEPS];
   logic [63:0]       rem_t [0:STEPS];
   logic [Q_BITS+1:0] den_t [0:STEPS];
   logic [Q_BITS-1:0] quo_t [0:STEPS];
   logic [SIDE_W-1:0] side_t [0:STEPS];

   // numerator 2^63 plus half the denominator gives round half up
   assign ctl_t[0] = ctl_in;
   assign den_t[0] = 34'(ONE_Q32) + 34'(e_in);
   assign rem_t[0] = {1'b1, 63'd0} + 64'(den_t[0] >> 1);
   assign quo_t[0] = '0;
   assign side_t[0] = side_in;

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam int J = STEPS - 1 - s;

      logm_ctl_type      ctl_ff;
      logic [64:0]       dsh;
      logic              ge;
      logic [63:0]       rem_in, rem_ff;
      logic [Q_BITS+1:0] den_ff;
      logic [Q_BITS-1:0] quo_in, quo_ff;
      logic [SIDE_W-1:0] side_ff;

      always_comb begin
         dsh = 65'(den_t[s]) << J;
         ge = 65'(rem_t[s]) >= dsh;
         rem_in = ge ? 64'(65'(rem_t[s]) - dsh) : rem_t[s];
         quo_in = quo_t[s] | (ge ? (32'(1) << J) : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else if (advance) begin
            ctl_ff <= ctl_t[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff <= rem_in;
            den_ff <= den_t[s];
            quo_ff <= quo_in;
            side_ff <= side_t[s];
         end
      end

      assign ctl_t[s+1] = ctl_ff;
      assign rem_t[s+1] = rem_ff;
      assign den_t[s+1] = den_ff;
      assign quo_t[s+1] = quo_ff;
      assign side_t[s+1] = side_ff;
   end

   assign ctl_out = ctl_t[STEPS];
   assign p_out = quo_t[STEPS];
   assign side_out = side_t[STEPS];

endmodule

// File: rtl/logistic_model_value_and_gradient.sv
// Top level: logistic model value c/(1+exp(-b(x-a))) and one selected partial derivative.
//
//  channel   dir  handshake        word
//  req_chan  in   valid/ready      x_value, derivative_index
//  rsp_chan  out  valid/ready      model_value, partial_value, saturated
//  csr_*     in   csr_we           csr_index, csr_wdata (coef_a, coef_b, coef_c)
//
// One word per cycle enters unless rsp_chan stalls; each word is offered on rsp_chan once it has passed every stage.
// The depth is set by three front stages, the 42-stage series evaluation, a clamp stage,
// 31 exp(-1) power stages, the 32-stage divider and four product and output stages.
// Reset clears all valid bits and loads a = 0, b = 1.0, c = 1.0.
// While a finished word waits on rsp_chan the whole pipeline holds; nothing is dropped.
module logistic_model_value_and_gradient
   import logm_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   logm_req_if.sink               req_chan,
   logm_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]  csr_wdata
);

   localparam int DW = DATA_WIDTH;
   localparam int XW = 2 * DW;
   localparam int RW = 2 * DW + 1;
   localparam int UW = 2 * DW + 33;
   localparam int PW = XW + 64;
   localparam int TF = 2 * FRAC_BITS;
   localparam int SH = (TF >= 32) ? TF - 32 : 0;
   localparam int LS = (TF >= 32) ? 0 : 32 - TF;
   localparam logic [UW-1:0] RND = (UW'(1) << SH) >> 1;

   function automatic logic [DW:0] sat_pack(input logic neg, input logic [RW-1:0] mag);
      logic [RW-1:0] lim;
      logic [DW:0]   res;
      lim = RW'(1) << (DW - 1);
      if (neg) begin
         if (mag > lim) begin
            res = {1'b1, 1'b1, {(DW-1){1'b0}}};
         end else begin
            res = {1'b0, DW'(~mag + 1'b1)};
         end
      end else begin
         if (mag > lim - RW'(1)) begin
            res = {1'b1, 1'b0, {(DW-1){1'b1}}};
         end else begin
            res = {1'b0, mag[DW-1:0]};
         end
      end
      return res;
   endfunction

   // coefficient registers
   logic [DW-1:0] coef_a_ff, coef_b_ff, coef_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= DW'(64'd1 << FRAC_BITS);
         coef_c_ff <= DW'(64'd1 << FRAC_BITS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_A: coef_a_ff <= csr_wdata;
            CSR_COEF_B: coef_b_ff <= csr_wdata;
            CSR_COEF_C: coef_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic          nb, nc;
   logic [DW-1:0] bm, cm;

   assign nb = coef_b_ff[DW-1];
   assign nc = coef_c_ff[DW-1];
   assign bm = nb ? ~coef_b_ff + 1'b1 : coef_b_ff;
   assign cm = nc ? ~coef_c_ff + 1'b1 : coef_c_ff;

   logic rsp_valid_ff;
   logic advance;

   // the pipeline moves whenever the output word is empty or being taken
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // stage 1: d = x - a as sign and magnitude
   logic [DW:0]   diff;
   logm_ctl_type  s1_ctl_in, s1_ctl_ff;
   logic [DW-1:0] s1_dm_in, s1_dm_ff;

   always_comb begin
      diff = {req_chan.x_value[DW-1], req_chan.x_value} - {coef_a_ff[DW-1], coef_a_ff};
      s1_dm_in = diff[DW] ? DW'(~diff + 1'b1) : diff[DW-1:0];
      s1_ctl_in = '{valid: req_chan.valid, big: 1'b0, nt: 1'b0, nd: diff[DW],
                    sel: req_chan.derivative_index};
   end

   // stage 2: |b| * |d|
   logm_ctl_type  s2_ctl_ff;
   logic [DW-1:0] s2_dm_ff;
   logic [XW-1:0] s2_p_ff;

   // stage 3: |t| in Q32 and the coefficient product for the derivative
   logic [UW-1:0] u_in;
   logm_ctl_type  s3_ctl_in, s3_ctl_ff;
   logic [XW-1:0] s3_x_in, s3_x_ff;
   logic [4:0]    s3_n_ff;
   logic [31:0]   s3_f_ff;

   always_comb begin
      u_in = ((UW'(s2_p_ff) + RND) >> SH) << LS;
      s3_ctl_in = s2_ctl_ff;
      s3_ctl_in.big = |u_in[UW-1:37];
      s3_ctl_in.nt = (nb != s2_ctl_ff.nd) && (|u_in);
      s3_x_in = XW'(cm) * XW'((s2_ctl_ff.sel == DERIV_A) ? bm : s2_dm_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dm_ff <= s1_dm_in;
         s2_dm_ff <= s1_dm_ff;
         s2_p_ff <= XW'(bm) * XW'(s1_dm_ff);
         s3_x_ff <= s3_x_in;
         s3_n_ff <= u_in[36:32];
         s3_f_ff <= u_in[31:0];
      end
   end

   logm_ctl_type  ex_ctl;
   logic [32:0]   ex_e;
   logic [XW-1:0] ex_x;

   logm_exp #(.SIDE_W(XW)) u_exp (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_in   (s3_ctl_ff),
      .n_in     (s3_n_ff),
      .f_in     (s3_f_ff),
      .side_in  (s3_x_ff),
      .ctl_out  (ex_ctl),
      .e_out    (ex_e),
      .side_out (ex_x)
   );

   logm_ctl_type  rc_ctl;
   logic [31:0]   rc_p;
   logic [XW-1:0] rc_x;

   logm_recip #(.SIDE_W(XW)) u_recip (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_in   (ex_ctl),
      .e_in     (ex_e),
      .side_in  (ex_x),
      .ctl_out  (rc_ctl),
      .p_out    (rc_p),
      .side_out (rc_x)
   );

   // stage G: s, g = p*(1-p) and c*s
   logic [31:0]    q_val, s_val;
   logm_ctl_type   g_ctl_ff;
   logic [31:0]    g_s_ff;
   logic [63:0]    g_g_ff;
   logic [DW+31:0] g_mv_ff;
   logic [XW-1:0]  g_x_ff;

   assign q_val = 32'h8000_0000 - rc_p;
   assign s_val = rc_ctl.nt ? q_val : rc_p;

   // stage M: rounded c*s and s, and the four partial products of the derivative
   logic [DW+32:0] mvr;
   logic [32:0]    sr;
   logic [RW-1:0]  mmag_in, smag;
   logm_ctl_type   m_ctl_ff;
   logic [63:0]    m_ll_ff, m_lh_ff;
   logic [XW-1:0]  m_hl_ff, m_hh_ff;
   logic [RW-1:0]  m_mmag_ff, m_smag_ff;

   always_comb begin
      mvr = (DW+33)'(g_mv_ff) + ((DW+33)'(1) << 30);
      mmag_in = RW'(mvr >> 31);
      sr = 33'(g_s_ff) + (33'(1) << (30 - FRAC_BITS));
      smag = RW'(sr >> (31 - FRAC_BITS));
   end

   // stage H: rounded derivative magnitude and its sign
   logic [PW-1:0]  pp;
   logic [RW-1:0]  pmag_prod, pmag_in;
   logic           pneg_in;
   logm_ctl_type   h_ctl_ff;
   logic [RW-1:0]  h_mmag_ff, h_pmag_ff;
   logic           h_pneg_ff;

   always_comb begin
      pp = (PW'(m_hh_ff) << 64) + (PW'(m_hl_ff) << 32) + (PW'(m_lh_ff) << 32)
           + PW'(m_ll_ff) + (PW'(1) << (FRAC_BITS + 61));
      pmag_prod = RW'(pp >> (FRAC_BITS + 62));
      case (m_ctl_ff.sel)
         DERIV_A: begin
            pmag_in = pmag_prod;
            pneg_in = (nc == nb);
         end
         DERIV_B: begin
            pmag_in = pmag_prod;
            pneg_in = (m_ctl_ff.nd != nc);
         end
         DERIV_C: begin
            pmag_in = m_smag_ff;
            pneg_in = 1'b0;
         end
         default: begin
            pmag_in = '0;
            pneg_in = 1'b0;
         end
      endcase
   end

   // output word: sign, clip and flag
   logic [DW:0]   model_pk, part_pk;
   logic [DW-1:0] rsp_model_ff, rsp_partial_ff;
   logic          rsp_sat_ff;

   assign model_pk = sat_pack(nc, h_mmag_ff);
   assign part_pk = sat_pack(h_pneg_ff, h_pmag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ctl_ff <= '0;
         m_ctl_ff <= '0;
         h_ctl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         g_ctl_ff <= rc_ctl;
         m_ctl_ff <= g_ctl_ff;
         h_ctl_ff <= m_ctl_ff;
         rsp_valid_ff <= h_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g_s_ff <= s_val;
         g_g_ff <= 64'(rc_p) * 64'(q_val);
         g_mv_ff <= (DW+32)'(cm) * (DW+32)'(s_val);
         g_x_ff <= rc_x;
         m_ll_ff <= 64'(g_x_ff[31:0]) * 64'(g_g_ff[31:0]);
         m_lh_ff <= 64'(g_x_ff[31:0]) * 64'(g_g_ff[63:32]);
         m_hl_ff <= XW'(g_x_ff[XW-1:32]) * XW'(g_g_ff[31:0]);
         m_hh_ff <= XW'(g_x_ff[XW-1:32]) * XW'(g_g_ff[63:32]);
         m_mmag_ff <= mmag_in;
         m_smag_ff <= smag;
         h_mmag_ff <= m_mmag_ff;
         h_pmag_ff <= pmag_in;
         h_pneg_ff <= pneg_in;
         rsp_model_ff <= model_pk[DW-1:0];
         rsp_partial_ff <= part_pk[DW-1:0];
         rsp_sat_ff <= model_pk[DW] | part_pk[DW];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.model_value = rsp_model_ff;
   assign rsp_chan.partial_value = rsp_partial_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   // logistic denominator lies in [1, 2], so p lies in [0.5, 1.0]
   a_p_range: assert property (@(posedge clock) disable iff (reset)
      rc_ctl.valid |-> (rc_p >= 32'h4000_0000 && rc_p <= 32'h8000_0000))
      else $error("reciprocal out of range");

   a_model_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !coef_c_ff[DW-1]) |-> !rsp_model_ff[DW-1])
      else $error("model value sign differs from c");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(h_ctl_ff) && $stable(h_pmag_ff) && $stable(g_ctl_ff)))
      else $error("pipeline moved during stall");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the logistic model value and gradient pipeline.
`timescale 1ns / 1ps

module testbench;
   import logm_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int PIPE_LATENCY = 112;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic signed [DW-1:0] model_value;
      logic signed [DW-1:0] partial_value;
      logic                 saturated;
   } logistic_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DW-1:0] csr_wdata;

   logm_req_if #(.DATA_WIDTH(DW)) req ();
   logm_rsp_if #(.DATA_WIDTH(DW)) rsp ();

   logistic_model_value_and_gradient #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [DW-1:0] mdl_a, mdl_b, mdl_c;
   logistic_word_type pending_words[$];
   int error_count = 0;
   int cycle_count = 0;
   bit no_idle = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // a*b*c >> sh, rounded half up; all ones and flag on overflow past 64 bits
   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] c, input int sh,
                                                  inout bit sat);
      logic [191:0] w;
      w = 192'(a) * 192'(b) * 192'(c);
      if (sh > 0) w = w + (192'(1) << (sh - 1));
      w = w >> sh;
      if (w[191:64] != 0) begin
         sat = 1;
         return '1;
      end
      return w[63:0];
   endfunction

   function automatic logic [DW-1:0] clip_signed(input bit neg, input logic [63:0] mag,
                                                 input bit sat, inout bit flag);
      logic [63:0] lim;
      lim = 64'(1) << (DW - 1);
      if (neg) begin
         if (sat || mag > lim) begin
            flag = 1;
            return lim[DW-1:0];
         end
         return DW'(64'(0) - mag);
      end
      if (sat || mag > lim - 1) begin
         flag = 1;
         return DW'(lim - 1);
      end
      return mag[DW-1:0];
   endfunction

   function automatic logic [63:0] magnitude_of(input logic [DW-1:0] v);
      logic [DW-1:0] n;
      n = ~v + 1'b1;
      return v[DW-1] ? 64'(n) : 64'(v);
   endfunction

   // exp(-f) in Q32 by a truncated Taylor series, f in [0, 1.0]
   function automatic logic [63:0] exp_neg_q32(input logic [63:0] f);
      logic signed [63:0] sum;
      logic [63:0] term;
      logic [127:0] prod;
      sum = 64'sh1_0000_0000;
      term = 64'h1_0000_0000;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         prod = 128'(term) * 128'(f);
         term = prod[95:32] / 64'(k);
         if (k % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sh1_0000_0000) sum = 64'sh1_0000_0000;
      return sum;
   endfunction

   function automatic logistic_word_type predict_logistic(input logic [DW-1:0] x,
                                                          input logic [1:0] sel);
      logistic_word_type r;
      bit nb, nc, nd, nt, tsat, flag, ms, ps, pneg;
      logic [63:0] bm, cm, dm, xs, as_, u, e, e1, p, q, s, g, pm, den;
      tsat = 0; flag = 0; ms = 0; ps = 0; pneg = 0; pm = 0;
      nb = mdl_b[DW-1];
      nc = mdl_c[DW-1];
      bm = magnitude_of(mdl_b);
      cm = magnitude_of(mdl_c);
      xs = 64'($signed(x));
      as_ = 64'($signed(mdl_a));
      nd = $signed(xs) < $signed(as_);
      dm = nd ? as_ - xs : xs - as_;
      u = scaled_product(bm, dm, 64'(1) << (32 - 2 * FB), 0, tsat);
      nt = (nb != nd) && (u != 0);
      if (tsat || (u >> 32) >= 32) begin
         e = 0;
      end else begin
         e1 = exp_neg_q32(64'h1_0000_0000);
         e = exp_neg_q32({32'd0, u[31:0]});
         for (int i = 0; i < int'(u >> 32); i++) e = (e * e1 + (64'(1) << 31)) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      p = ((64'(1) << 63) + den / 2) / den;
      q = (64'(1) << 31) - p;
      s = nt ? q : p;
      g = p * q;
      r.model_value = clip_signed(nc, scaled_product(cm, s, 1, 31, ms), ms, flag);
      case (sel)
         DERIV_A: begin
            pm = scaled_product(cm, bm, g, FB + 62, ps);
            pneg = (nc == nb);
         end
         DERIV_B: begin
            pm = scaled_product(dm, cm, g, FB + 62, ps);
            pneg = (nd != nc);
         end
         DERIV_C: pm = scaled_product(s, 1, 1, 31 - FB, ps);
         default: pm = 0;
      endcase
      r.partial_value = clip_signed(pneg, pm, ps, flag);
      r.saturated = flag;
      return r;
   endfunction

   task automatic write_coef(input logic [CSR_INDEX_W-1:0] idx, input logic [DW-1:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         CSR_COEF_A: mdl_a = val;
         CSR_COEF_B: mdl_b = val;
         CSR_COEF_C: mdl_c = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send_sample(input logic [DW-1:0] x, input logic [1:0] sel);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req.valid = 0;
      end
      @(negedge clock);
      req.valid = 1;
      req.x_value = x;
      req.derivative_index = sel;
      do @(posedge clock); while (!req.ready);
      pending_words.push_back(predict_logistic(x, sel));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req.valid = 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   // response side: random backpressure, compare in order
   initial begin
      logistic_word_type exp_w;
      int stall;
      rsp.ready = 0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            @(negedge clock);
            rsp.ready = 0;
         end
         @(negedge clock);
         rsp.ready = 1;
         do @(posedge clock); while (!rsp.valid);
         if (pending_words.size() == 0) begin
            $error("unexpected word: model_value %0d", rsp.model_value);
            error_count++;
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp.model_value !== exp_w.model_value) begin
               $error("model_value expected %0d actual %0d", exp_w.model_value,
                      rsp.model_value);
               error_count++;
            end
            if (rsp.partial_value !== exp_w.partial_value) begin
               $error("partial_value expected %0d actual %0d", exp_w.partial_value,
                      rsp.partial_value);
               error_count++;
            end
            if (rsp.saturated !== exp_w.saturated) begin
               $error("saturated expected %0d actual %0d", exp_w.saturated, rsp.saturated);
               error_count++;
            end
         end
      end
   end

   function automatic logic [DW-1:0] random_x();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return mdl_a + DW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         2: return mdl_a + DW'($signed($urandom_range(0, 64 << FB)) - (32 << FB));
         default: return DW'($signed($urandom_range(0, 2000 << FB)) - (1000 << FB));
      endcase
   endfunction

   task automatic test_reset_defaults();
      logic [DW-1:0] xs[8];
      xs = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'h0001_0000, 32'hffff_0000,
             32'h0020_0000, 32'hffe0_0000, 32'h0000_0001};
      foreach (xs[i]) send_sample(xs[i], 2'(i % 4));
      for (int s = 0; s < 4; s++) send_sample(32'h0000_8000, 2'(s));
      wait_drained();
   endtask

   task automatic test_saturation();
      write_coef(CSR_COEF_A, 32'h8000_0000);
      write_coef(CSR_COEF_B, 32'h7fff_ffff);
      write_coef(CSR_COEF_C, 32'h8000_0000);
      write_coef(2'd3, 32'h1234_5678);  // ignored index
      for (int s = 0; s < 4; s++) send_sample(32'h7fff_ffff, 2'(s));
      wait_drained();
      write_coef(CSR_COEF_B, 32'h0000_0001);
      for (int s = 0; s < 4; s++) send_sample(32'h7fff_ffff, 2'(s));
      wait_drained();
      write_coef(CSR_COEF_A, 32'h0000_0000);
      write_coef(CSR_COEF_B, 32'h8000_0000);
      write_coef(CSR_COEF_C, 32'h7fff_ffff);
      for (int s = 0; s < 4; s++) send_sample(32'h0000_4000, 2'(s));
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 10; phase++) begin
         no_idle = (phase % 3 == 1);
         case (phase)
            0: begin
               write_coef(CSR_COEF_A, 32'h7fff_ffff);
               write_coef(CSR_COEF_B, 32'hffff_0000);
               write_coef(CSR_COEF_C, 32'h7fff_ffff);
            end
            1: begin
               write_coef(CSR_COEF_A, 0);
               write_coef(CSR_COEF_B, 32'h0001_0000);
               write_coef(CSR_COEF_C, 32'h0001_0000);
            end
            default: begin
               write_coef(CSR_COEF_A, DW'($signed($urandom_range(0, 20 << FB)) - (10 << FB)));
               write_coef(CSR_COEF_B, ($urandom_range(0, 3) == 0) ? $urandom() :
                          DW'($signed($urandom_range(0, 8 << FB)) - (4 << FB)));
               write_coef(CSR_COEF_C, ($urandom_range(0, 3) == 0) ? $urandom() :
                          DW'($signed($urandom_range(0, 200 << FB)) - (100 << FB)));
            end
         endcase
         repeat (52) send_sample(random_x(), 2'($urandom_range(0, 3)));
         wait_drained();
      end
      no_idle = 0;
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      req.valid = 0;
      req.x_value = 0;
      req.derivative_index = 0;
      mdl_a = 0;
      mdl_b = 32'h0001_0000;
      mdl_c = 32'h0001_0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_reset_defaults();
      test_saturation();
      test_random_settings();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: logistic_model_value_and_gradient.f
rtl/logm_pkg.sv
rtl/logm_if.sv
rtl/logm_exp.sv
rtl/logm_recip.sv
rtl/logistic_model_value_and_gradient.sv
tb/testbench.sv
